// ===== src/hgl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heightfield gradient / Laplacian block.
// No dependencies.
package hgl_pkg;

    // Default grid limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths
    localparam int SAMPLE_W     = 16;
    localparam int RESULT_W     = 32;
    localparam int COORD_W      = 10;
    localparam int CFG_DIM_W    = 11;
    localparam int CFG_FACTOR_W = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int RADICAND_W   = 64;
    localparam int OUT_TDATA_W  = 152;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_FACTOR    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_FACTOR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAP_FACTOR  = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DIM_W-1:0]    RST_GRID_WIDTH  = 11'd1024;
    localparam logic [CFG_DIM_W-1:0]    RST_GRID_HEIGHT = 11'd1024;
    localparam logic [CFG_FACTOR_W-1:0] RST_X_FACTOR    = 16'd128;
    localparam logic [CFG_FACTOR_W-1:0] RST_Y_FACTOR    = 16'd128;
    localparam logic [CFG_FACTOR_W-1:0] RST_LAP_FACTOR  = 16'd256;

    // Input item kinds (tuser)
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_MID,
        ST_RD_SIDE,
        ST_SAT_SQ,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_EMIT
    } t_state;

    // Square-root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

endpackage

// ===== src/heightfield_gradient_laplacian.sv =====
`timescale 1ns / 1ps
// Heightfield gradient, slope and five-point Laplacian over a raster stream.
// Depends on hgl_pkg, hgl_row_mem and hgl_isqrt.
//
// Samples enter in raster order on the slave stream (tuser=0); the result for
// a grid point leaves one row later, and after the last row each flush tick
// (tuser=1) drains one point of that row, left to right, tlast marking the
// final point. Items that give no result (first-row samples, ignored samples
// and flushes outside the drain) stay in the idle state. An item that gives a
// result passes the row-store reads (ST_RD_MID, then ST_RD_SIDE, which also
// multiplies), a saturate-and-square state and the bit-serial slope root.
// The next item is taken while a finished result still waits on the master
// stream. Both row stores come up undefined and need no clearing after reset.
module heightfield_gradient_laplacian
    import hgl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]    i_s_axis_tdata,  // [15:0] height_sample
    input  logic [0:0]             i_s_axis_tuser,  // [0] mode
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] gradient_x, [63:32] gradient_y, [95:64] slope_magnitude,
    // [127:96] laplacian_value, [137:128] point_column, [147:138] point_row
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast,  // frame_last
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;
    localparam int GXW = SAMPLE_W + 1 + CFG_FACTOR_W + 1;
    localparam int NW  = SAMPLE_W + 3;
    localparam int LPW = NW + CFG_FACTOR_W + 1;

    // Configuration registers
    logic [CFG_DIM_W-1:0]    r_cfg_width, r_cfg_height;
    logic [CFG_FACTOR_W-1:0] r_cfg_xf, r_cfg_yf, r_cfg_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_GRID_WIDTH;
            r_cfg_height <= RST_GRID_HEIGHT;
            r_cfg_xf     <= RST_X_FACTOR;
            r_cfg_yf     <= RST_Y_FACTOR;
            r_cfg_lf     <= RST_LAP_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_HEIGHT: r_cfg_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_X_FACTOR:    r_cfg_xf     <= i_cfg_data;
                CFG_Y_FACTOR:    r_cfg_yf     <= i_cfg_data;
                CFG_LAP_FACTOR:  r_cfg_lf     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid size, clamped to [2, MAX]
    logic [WW-1:0] cfg_w_ext, eff_w;
    logic [HW-1:0] cfg_h_ext, eff_h;

    always_comb begin
        cfg_w_ext = WW'(r_cfg_width);
        cfg_h_ext = HW'(r_cfg_height);
        if (cfg_w_ext < WW'(2))              eff_w = WW'(2);
        else if (cfg_w_ext > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
        else                                 eff_w = cfg_w_ext;
        if (cfg_h_ext < HW'(2))               eff_h = HW'(2);
        else if (cfg_h_ext > HW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
        else                                  eff_h = cfg_h_ext;
    end

    // Sequencer and per-item registers
    t_state                   r_state, n_state;
    logic [AW-1:0]            r_in_col, n_in_col;
    logic [HW-1:0]            r_in_row, n_in_row;
    logic [AW-1:0]            r_drain_col, n_drain_col;
    logic [AW-1:0]            r_c, n_c;
    logic [HW-1:0]            r_row_out, n_row_out;
    logic                     r_has_up, n_has_up;
    logic                     r_has_down, n_has_down;
    logic                     r_last, n_last;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SAMPLE_W-1:0] r_mid, r_up;
    logic signed [GXW-1:0]    r_gx_raw, r_gy_raw;
    logic signed [LPW-1:0]    r_lap_raw;
    logic signed [RESULT_W-1:0] r_gx, r_gy, r_lap;
    logic [2*RESULT_W-1:0]    r_sq_x, r_sq_y;

    logic                     in_xfer;
    logic [AW-1:0]            acc_c;
    logic [AW-1:0]            acc_drain;
    logic                     cen_we;
    logic [AW-1:0]            cen_wa, cen_ra, prv_ra;
    logic [SAMPLE_W-1:0]      cen_wd;
    logic [SAMPLE_W-1:0]      cen_rd, prv_rd;
    logic                     prv_we;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Clamped column for an incoming sample or flush
    always_comb begin
        acc_c     = (WW'(r_in_col) >= eff_w) ? AW'(eff_w - 1'b1) : r_in_col;
        acc_drain = (WW'(r_drain_col) >= eff_w) ? AW'(eff_w - 1'b1) : r_drain_col;
    end

    // Result stream register
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic                  emit_load;
    t_root_stat            root_stat;
    logic [RESULT_W-1:0]   root_val;
    logic [31:0]           col_ext, row_ext;

    assign emit_load = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);

    // Accept decode and next state
    always_comb begin
        n_state     = r_state;
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_drain_col = r_drain_col;
        n_c         = r_c;
        n_row_out   = r_row_out;
        n_has_up    = r_has_up;
        n_has_down  = r_has_down;
        n_last      = r_last;
        n_sample    = r_sample;
        cen_we      = 1'b0;
        cen_wa      = r_c;
        cen_wd      = r_sample;
        prv_we      = 1'b0;
        cen_ra      = r_c + 1'b1;
        prv_ra      = r_c - 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                cen_ra = (i_s_axis_tuser[0] == MODE_FLUSH) ? acc_drain : acc_c;
                prv_ra = cen_ra;
                if (in_xfer) begin
                    if (i_s_axis_tuser[0] == MODE_SAMPLE) begin
                        if (r_in_row < eff_h) begin
                            n_c        = acc_c;
                            n_sample   = i_s_axis_tdata;
                            n_row_out  = r_in_row - 1'b1;
                            n_has_up   = (r_in_row >= HW'(2));
                            n_has_down = 1'b1;
                            n_last     = 1'b0;
                            if (r_in_row == '0) begin
                                // first row only fills the center store
                                cen_we = 1'b1;
                                cen_wa = acc_c;
                                cen_wd = i_s_axis_tdata;
                            end else begin
                                n_state = ST_RD_MID;
                            end
                            if (WW'(acc_c) + 1'b1 >= eff_w) begin
                                n_in_col = '0;
                                n_in_row = r_in_row + 1'b1;
                            end else begin
                                n_in_col = acc_c + 1'b1;
                            end
                        end
                    end else if (r_in_row >= eff_h) begin
                        n_c        = acc_drain;
                        n_row_out  = eff_h - 1'b1;
                        n_has_up   = 1'b1;
                        n_has_down = 1'b0;
                        n_last     = (WW'(acc_drain) + 1'b1 >= eff_w);
                        n_state    = ST_RD_MID;
                        if (WW'(acc_drain) + 1'b1 >= eff_w) begin
                            n_in_col    = '0;
                            n_in_row    = '0;
                            n_drain_col = '0;
                        end else begin
                            n_drain_col = acc_drain + 1'b1;
                        end
                    end
                end
            end
            ST_RD_MID:  n_state = ST_RD_SIDE;
            ST_RD_SIDE: begin
                // shift the center entry down, store the new sample
                prv_we  = 1'b1;
                cen_we  = r_has_down;
                n_state = ST_SAT_SQ;
            end
            ST_SAT_SQ:    n_state = ST_ROOT_GO;
            ST_ROOT_GO:   n_state = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (root_stat.done) n_state = ST_EMIT;
            ST_EMIT:      if (emit_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_drain_col <= '0;
        end else begin
            r_state     <= n_state;
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_drain_col <= n_drain_col;
        end
        r_c        <= n_c;
        r_row_out  <= n_row_out;
        r_has_up   <= n_has_up;
        r_has_down <= n_has_down;
        r_last     <= n_last;
        r_sample   <= n_sample;
    end

    // Row stores
    hgl_row_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SAMPLE_W)
    ) u_center_mem (
        .i_clk     (i_clk),
        .i_rd_addr (cen_ra),
        .o_rd_data (cen_rd),
        .i_wr_en   (cen_we),
        .i_wr_addr (cen_wa),
        .i_wr_data (cen_wd)
    );

    hgl_row_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SAMPLE_W)
    ) u_prev_mem (
        .i_clk     (i_clk),
        .i_rd_addr (prv_ra),
        .o_rd_data (prv_rd),
        .i_wr_en   (prv_we),
        .i_wr_addr (r_c),
        .i_wr_data (r_mid)
    );

    // Neighbor selection and first multiply stage
    logic signed [SAMPLE_W-1:0] nb_up, nb_left, nb_right, nb_down;
    logic signed [SAMPLE_W:0]   dx, dy;
    logic signed [NW-1:0]       num;

    always_comb begin
        nb_up    = r_has_up ? r_up : r_mid;
        nb_left  = (r_c != '0) ? $signed(prv_rd) : r_mid;
        nb_right = (WW'(r_c) + 1'b1 < eff_w) ? $signed(cen_rd) : r_mid;
        nb_down  = r_has_down ? r_sample : r_mid;
        dx  = (SAMPLE_W+1)'(nb_left) - (SAMPLE_W+1)'(nb_right);
        dy  = (SAMPLE_W+1)'(nb_up) - (SAMPLE_W+1)'(nb_down);
        num = NW'(nb_left) + NW'(nb_right) + NW'(nb_up) + NW'(nb_down)
              - (NW'(r_mid) <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_MID) begin
            r_mid <= $signed(cen_rd);
            r_up  <= $signed(prv_rd);
        end
        if (r_state == ST_RD_SIDE) begin
            r_gx_raw  <= GXW'(dx) * $signed(GXW'({1'b0, r_cfg_xf}));
            r_gy_raw  <= GXW'(dy) * $signed(GXW'({1'b0, r_cfg_yf}));
            r_lap_raw <= LPW'(num) * $signed(LPW'({1'b0, r_cfg_lf}));
        end
    end

    // Saturation and squaring
    logic signed [RESULT_W-1:0] gx_sat, gy_sat, lap_sat;
    localparam logic signed [RESULT_W-1:0] SAT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] SAT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    always_comb begin
        if (r_gx_raw > GXW'(SAT_MAX))      gx_sat = SAT_MAX;
        else if (r_gx_raw < GXW'(SAT_MIN)) gx_sat = SAT_MIN;
        else                               gx_sat = r_gx_raw[RESULT_W-1:0];
        if (r_gy_raw > GXW'(SAT_MAX))      gy_sat = SAT_MAX;
        else if (r_gy_raw < GXW'(SAT_MIN)) gy_sat = SAT_MIN;
        else                               gy_sat = r_gy_raw[RESULT_W-1:0];
        if (r_lap_raw > LPW'(SAT_MAX))      lap_sat = SAT_MAX;
        else if (r_lap_raw < LPW'(SAT_MIN)) lap_sat = SAT_MIN;
        else                                lap_sat = r_lap_raw[RESULT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SAT_SQ) begin
            r_gx   <= gx_sat;
            r_gy   <= gy_sat;
            r_lap  <= lap_sat;
            r_sq_x <= (2*RESULT_W)'((2*RESULT_W)'(gx_sat) * (2*RESULT_W)'(gx_sat));
            r_sq_y <= (2*RESULT_W)'((2*RESULT_W)'(gy_sat) * (2*RESULT_W)'(gy_sat));
        end
    end

    // Slope: floor root of the summed squares
    hgl_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_ROOT_GO),
        .i_radicand (r_sq_x + r_sq_y),
        .o_stat     (root_stat),
        .o_root     (root_val)
    );

    // Output register: loads when empty or being drained
    assign col_ext = 32'(r_c);
    assign row_ext = 32'(r_row_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (emit_load) begin
            r_out_data <= {4'b0, row_ext[COORD_W-1:0], col_ext[COORD_W-1:0],
                           r_lap, root_val, r_gy, r_gx};
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Checks
    a_root_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_stat.done |-> (r_state == ST_ROOT_WAIT))
        else $error("root done outside wait state");

    a_root_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT_GO) |=> root_stat.busy)
        else $error("root unit did not start");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_last) |=> (r_in_row == '0 && r_drain_col == '0))
        else $error("counters not cleared at frame end");

endmodule

// ===== src/hgl_row_mem.sv =====
`timescale 1ns / 1ps
// One row store: synchronous RAM, one write and one registered read port.
// Depends on nothing but its parameters.
module hgl_row_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/hgl_isqrt.sv =====
`timescale 1ns / 1ps
// Floor square root of a 64-bit value, one root bit per cycle.
// Depends on hgl_pkg.
module hgl_isqrt
    import hgl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RADICAND_W-1:0] i_radicand,
    output t_root_stat            o_stat,
    output logic [RESULT_W-1:0]   o_root
);

    localparam int CNT_W = $clog2(RESULT_W);
    localparam int REM_W = RESULT_W + 3;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [RADICAND_W-1:0] r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [RESULT_W-1:0]   r_root, n_root;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    // Digit-by-digit recurrence: bring down two bits, try root*4+1
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        rem_sh = {r_rem[REM_W-3:0], r_rad[RADICAND_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RESULT_W - 1);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[RADICAND_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[RESULT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[RESULT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule
